>>> hw/rtl/iphc_pkg.sv
`timescale 1ns / 1ps
// Package for the IPv4 address hit counter: table geometry, outcome codes,
// controller states, command/status structs and the slot hash. No dependencies.
package iphc_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [15:0] IPV4_ETHER_TYPE  = 16'd2048;
    localparam logic [13:0] MIN_FRAME_LENGTH = 14'd34;
    localparam logic [31:0] HASH_MULT        = 32'h9E37_79B1;

    typedef enum logic [1:0] {
        OUT_HIT         = 2'd0,
        OUT_INSERTED    = 2'd1,
        OUT_FULL        = 2'd2,
        OUT_NOT_COUNTED = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic valid;
        logic [31:0] addr;
        logic [63:0] dest_hits;
        logic [63:0] src_hits;
    } entry_t;

    typedef struct packed {
        logic clr_step;
        logic latch;
        logic hash;
        logic rd;
        logic first;
        logic check;
        logic side;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic counted;
        logic resolved;
    } dp_status_t;

    // Multiplicative hash: upper product bits, folded once into the table range.
    function automatic logic [IDX_W-1:0] hash_idx(input logic [31:0] a);
        logic [31:0] prod;
        logic [31:0] top;
        prod = a * HASH_MULT;
        top  = 32'(prod[31 -: IDX_W]);
        if (top >= 32'(TABLE_ENTRIES))
        begin
            top = top - 32'(TABLE_ENTRIES);
        end
        return top[IDX_W-1:0];
    endfunction

endpackage

>>> hw/rtl/iphc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the IPv4 address hit counter.
// Depends on iphc_pkg; drives the datapath through iphc_pkg::ctrl_cmd_t.
module iphc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  iphc_pkg::dp_status_t   status_in,
    output iphc_pkg::ctrl_cmd_t    cmd,
    output logic                   busy
);

    iphc_pkg::state_t state_reg, state_next;
    logic side_reg, side_next;
    logic first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iphc_pkg::ST_CLEAR;
            side_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            first_reg <= first_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        first_next = first_reg;
        cmd        = '0;
        cmd.side   = side_reg;
        cmd.first  = first_reg;
        busy       = 1'b1;
        case (state_reg)
            iphc_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status_in.clr_last)
                begin
                    state_next = iphc_pkg::ST_IDLE;
                end
            end
            iphc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = iphc_pkg::ST_HASH;
                end
            end
            iphc_pkg::ST_HASH:
            begin
                cmd.hash   = 1'b1;
                side_next  = 1'b0;
                first_next = 1'b1;
                state_next = status_in.counted ? iphc_pkg::ST_READ : iphc_pkg::ST_DONE;
            end
            iphc_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                first_next = 1'b0;
                state_next = iphc_pkg::ST_CHECK;
            end
            iphc_pkg::ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = iphc_pkg::ST_READ;
                if (status_in.resolved)
                begin
                    if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        first_next = 1'b1;
                    end
                    else
                    begin
                        state_next = iphc_pkg::ST_DONE;
                    end
                end
            end
            iphc_pkg::ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = iphc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = iphc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/iphc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the IPv4 address hit counter: request registers, hash, the slot
// table memory with linear probing, and the result registers. Depends on iphc_pkg.
module iphc_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iphc_pkg::ctrl_cmd_t    cmd,
    output iphc_pkg::dp_status_t   status_out,
    input  logic [13:0]            frame_length,
    input  logic [15:0]            ether_type,
    input  logic [31:0]            dest_addr,
    input  logic [31:0]            src_addr,
    output logic                   done,
    output logic                   status,
    output logic [1:0]             dest_outcome,
    output logic [1:0]             src_outcome,
    output logic [63:0]            dest_count,
    output logic [63:0]            src_count
);

    localparam logic [iphc_pkg::IDX_W-1:0] LAST_IDX =
        iphc_pkg::IDX_W'(iphc_pkg::TABLE_ENTRIES - 1);

    iphc_pkg::entry_t mem [iphc_pkg::TABLE_ENTRIES];
    iphc_pkg::entry_t rd_reg;
    iphc_pkg::entry_t wdata;
    logic             we;

    logic [31:0] daddr_reg, saddr_reg;
    logic        counted_reg;
    logic [iphc_pkg::IDX_W-1:0] dhash_reg, shash_reg;
    logic [iphc_pkg::IDX_W-1:0] probe_reg, probe_next;
    logic [iphc_pkg::IDX_W-1:0] probes_reg;
    logic [iphc_pkg::IDX_W-1:0] rd_idx;

    iphc_pkg::outcome_t dout_reg, sout_reg, outcome_now;
    logic [63:0] dcount_reg, scount_reg, count_now;

    logic done_reg, status_reg;
    logic [1:0] dest_outcome_reg, src_outcome_reg;
    logic [63:0] dest_count_reg, src_count_reg;

    logic [31:0] cur_addr;
    logic hit, empty, last_probe;

    assign cur_addr   = cmd.side ? saddr_reg : daddr_reg;
    assign hit        = rd_reg.valid && (rd_reg.addr == cur_addr);
    assign empty      = !rd_reg.valid;
    assign last_probe = (probes_reg == LAST_IDX);
    assign rd_idx     = cmd.first ? (cmd.side ? shash_reg : dhash_reg) : probe_reg;
    assign probe_next = (probe_reg == LAST_IDX) ? '0 : probe_reg + 1'b1;

    assign status_out.clr_last = (probe_reg == LAST_IDX);
    assign status_out.counted  = counted_reg;
    assign status_out.resolved = hit || empty || last_probe;

    always_comb
    begin
        wdata       = rd_reg;
        we          = 1'b0;
        outcome_now = iphc_pkg::OUT_FULL;
        count_now   = '0;
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            wdata = '0;
        end
        else if (cmd.check)
        begin
            if (hit)
            begin
                we          = 1'b1;
                outcome_now = iphc_pkg::OUT_HIT;
                if (cmd.side)
                begin
                    wdata.src_hits = rd_reg.src_hits + 64'd1;
                    count_now      = wdata.src_hits;
                end
                else
                begin
                    wdata.dest_hits = rd_reg.dest_hits + 64'd1;
                    count_now       = wdata.dest_hits;
                end
            end
            else if (empty)
            begin
                we              = 1'b1;
                outcome_now     = iphc_pkg::OUT_INSERTED;
                wdata.valid     = 1'b1;
                wdata.addr      = cur_addr;
                wdata.dest_hits = {63'd0, !cmd.side};
                wdata.src_hits  = {63'd0, cmd.side};
                count_now       = 64'd1;
            end
        end
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[probe_reg] <= wdata;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg   <= '0;
            done_reg    <= 1'b0;
            counted_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.clr_step)
            begin
                probe_reg <= probe_next;
            end
            else if (cmd.rd)
            begin
                probe_reg <= rd_idx;
            end
            else if (cmd.check && !status_out.resolved)
            begin
                probe_reg <= probe_next;
            end
            if (cmd.latch)
            begin
                counted_reg <= (ether_type == iphc_pkg::IPV4_ETHER_TYPE) &&
                               (frame_length >= iphc_pkg::MIN_FRAME_LENGTH);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            daddr_reg  <= dest_addr;
            saddr_reg  <= src_addr;
            dout_reg   <= iphc_pkg::OUT_NOT_COUNTED;
            sout_reg   <= iphc_pkg::OUT_NOT_COUNTED;
            dcount_reg <= '0;
            scount_reg <= '0;
        end
        if (cmd.hash)
        begin
            dhash_reg <= iphc_pkg::hash_idx(daddr_reg);
            shash_reg <= iphc_pkg::hash_idx(saddr_reg);
        end
        if (cmd.rd && cmd.first)
        begin
            probes_reg <= '0;
        end
        else if (cmd.check && !status_out.resolved)
        begin
            probes_reg <= probes_reg + 1'b1;
        end
        if (cmd.check && status_out.resolved)
        begin
            if (cmd.side)
            begin
                sout_reg   <= outcome_now;
                scount_reg <= count_now;
            end
            else
            begin
                dout_reg   <= outcome_now;
                dcount_reg <= count_now;
            end
        end
        if (cmd.finish)
        begin
            status_reg       <= counted_reg;
            dest_outcome_reg <= dout_reg;
            src_outcome_reg  <= sout_reg;
            dest_count_reg   <= dcount_reg;
            src_count_reg    <= scount_reg;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign dest_outcome = dest_outcome_reg;
    assign src_outcome  = src_outcome_reg;
    assign dest_count   = dest_count_reg;
    assign src_count    = src_count_reg;

endmodule

>>> hw/rtl/ipv4_address_hit_counter.sv
`timescale 1ns / 1ps
// Top level of the IPv4 address hit counter: controller plus datapath.
// Depends on iphc_pkg, iphc_ctrl and iphc_datapath.
//
//  Channel   Handshake            Fields
//  -------   ------------------   ----------------------------------------------
//  request   start, busy          frame_length, ether_type, dest_addr, src_addr
//  result    done (1-cycle pulse) status, dest_outcome, src_outcome,
//                                 dest_count, src_count
//
// A request is taken on a clock edge where start is high and busy is low.
// An ignored frame skips the table and returns its result straight after the
// hash step. A counted frame probes for the destination, then for the source;
// each probe is one read and one compare of the slot table, so a sparse table
// needs one probe per address.
// After reset the table is cleared one slot per cycle, with busy held high
// until all TABLE_ENTRIES (1024) slots are clear. The result strobe cannot
// be stalled; it lasts exactly one cycle, during which busy is already low.
//
// Addresses are placed with a multiplicative hash and linear probing. A
// lookup stops at the matching slot or the first empty one; when every slot
// has been probed without either, the table is full and the insert is dropped.
module ipv4_address_hit_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [13:0] frame_length,
    input  logic [15:0] ether_type,
    input  logic [31:0] dest_addr,
    input  logic [31:0] src_addr,
    output logic        done,
    output logic        status,
    output logic [1:0]  dest_outcome,
    output logic [1:0]  src_outcome,
    output logic [63:0] dest_count,
    output logic [63:0] src_count
);

    iphc_pkg::ctrl_cmd_t  cmd;
    iphc_pkg::dp_status_t dp_status;

    // The controller sequences hashing, probing and result issue.
    iphc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .status_in (dp_status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // The datapath holds the request, the slot table and the result registers.
    iphc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status_out   (dp_status),
        .frame_length (frame_length),
        .ether_type   (ether_type),
        .dest_addr    (dest_addr),
        .src_addr     (src_addr),
        .done         (done),
        .status       (status),
        .dest_outcome (dest_outcome),
        .src_outcome  (src_outcome),
        .dest_count   (dest_count),
        .src_count    (src_count)
    );

endmodule
